// ===== hw/rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color block.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int DEF_PALETTE_DEPTH = 256;
    localparam int CHAN_W            = 8;
    localparam int ENTRY_W           = 3 * CHAN_W;
    localparam int COLOR_IDX_W       = 8;
    localparam int COUNT_W           = 9;
    localparam int SQ_W              = 2 * CHAN_W;
    // 3 * 255^2 = 195075 fits in 18 bits
    localparam int DIST_W            = SQ_W + 2;
    localparam int IN_DATA_W         = COLOR_IDX_W + ENTRY_W;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } npc_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } npc_state_t;

    // one palette entry on its way through the distance pipeline
    typedef struct packed
    {
        logic                   valid;
        logic                   last;
        logic [COLOR_IDX_W-1:0] idx;
    } npc_cand_t;

endpackage

// ===== hw/rtl/npc_store.sv =====
// ----------------------------------------------------------------------------
// npc_store
// Palette memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module npc_store #(
    parameter int DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [npc_pkg::ENTRY_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [npc_pkg::ENTRY_W-1:0]  rd_data
);
    import npc_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist
// Two-stage squared RGB distance and running minimum over a palette scan.
// ----------------------------------------------------------------------------
module npc_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [npc_pkg::ENTRY_W-1:0]       entry,
    input  logic [npc_pkg::ENTRY_W-1:0]       pixel,
    input  npc_pkg::npc_cand_t                cand,
    output logic                              done,
    output logic [npc_pkg::COLOR_IDX_W-1:0]   best_idx
);
    import npc_pkg::*;

    logic [CHAN_W-1:0]      d_r, d_g, d_b;
    logic [SQ_W-1:0]        sq_r_reg, sq_g_reg, sq_b_reg;
    npc_cand_t              cand_a_reg;
    logic [DIST_W-1:0]      dist_sum;
    logic [DIST_W-1:0]      best_dist_reg;
    logic [COLOR_IDX_W-1:0] best_idx_reg;
    logic                   done_reg;
    logic                   better;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign d_r = abs_diff(entry[3*CHAN_W-1:2*CHAN_W], pixel[3*CHAN_W-1:2*CHAN_W]);
    assign d_g = abs_diff(entry[2*CHAN_W-1:CHAN_W],   pixel[2*CHAN_W-1:CHAN_W]);
    assign d_b = abs_diff(entry[CHAN_W-1:0],          pixel[CHAN_W-1:0]);

    // stage A: squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_a_reg <= '0;
        end
        else
        begin
            cand_a_reg <= cand;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(d_r * d_r);
        sq_g_reg <= SQ_W'(d_g * d_g);
        sq_b_reg <= SQ_W'(d_b * d_b);
    end

    // stage B: sum and compare; strict less keeps the first entry on ties
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better   = cand_a_reg.valid && (dist_sum < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cand_a_reg.valid && cand_a_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (better)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= cand_a_reg.idx;
        end
    end

    assign done     = done_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== hw/rtl/nearest_palette_color_top.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_top
// Maps an RGB pixel to the index of the nearest palette entry (squared
// Euclidean distance, lowest index on ties); also loads palette entries.
// ----------------------------------------------------------------------------
// Palette write: no result item; writes can follow back to back.
// Lookup: the scan reads min(count, depth, 256) memory entries, one per cycle,
//   through the single read port, into the result register.
// Empty palette lookup: index 0 with the empty flag.
// After a lookup the next item is taken only once the result has moved to the
//   output register, later while that register is still held by the sink.
// Reset clears control state and palette_count; palette memory is not cleared.
module nearest_palette_color_top #(
    parameter int PALETTE_DEPTH = npc_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config: palette_count
    input  logic                                cfg_wr_en,
    input  logic [npc_pkg::COUNT_W-1:0]         cfg_wr_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [npc_pkg::IN_DATA_W-1:0]       s_tdata,
    // operation[0]
    input  logic                                s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // color_index[7:0]
    output logic [npc_pkg::COLOR_IDX_W-1:0]     m_tdata,
    // palette_empty[0]
    output logic                                m_tuser
);
    import npc_pkg::*;

    localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
    localparam int WIDE_W  = (ADDR_W > COLOR_IDX_W) ? ADDR_W : COLOR_IDX_W;
    localparam int LIM_MAX = (PALETTE_DEPTH < (1 << COLOR_IDX_W)) ?
                             PALETTE_DEPTH : (1 << COLOR_IDX_W);
    localparam logic [COUNT_W-1:0]  LIM_MAX_C = COUNT_W'(LIM_MAX);
    localparam logic [WIDE_W:0]     DEPTH_C   = (WIDE_W + 1)'(PALETTE_DEPTH);

    npc_state_t             state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     limit_reg, limit_next;
    logic [COUNT_W-1:0]     issue_reg, issue_next;
    logic [ENTRY_W-1:0]     pix_reg, pix_next;
    npc_cand_t              cand_reg, cand_next;
    logic [COLOR_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic                   res_empty_reg, res_empty_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [COLOR_IDX_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   accept;
    npc_op_t                op;
    logic [ENTRY_W-1:0]     in_rgb;
    logic [WIDE_W-1:0]      wr_wide;
    logic [WIDE_W-1:0]      rd_wide;
    logic                   wr_en;
    logic                   rd_en;
    logic [COUNT_W-1:0]     limit_now;
    logic                   start;
    logic                   load_out;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   dist_done;
    logic [COLOR_IDX_W-1:0] dist_best;

    assign op      = npc_op_t'(s_tuser);
    assign accept  = s_tvalid && s_tready;
    assign in_rgb  = {s_tdata[2*CHAN_W-1:CHAN_W], s_tdata[3*CHAN_W-1:2*CHAN_W],
                      s_tdata[4*CHAN_W-1:3*CHAN_W]};
    assign wr_wide = WIDE_W'(s_tdata[COLOR_IDX_W-1:0]);
    assign rd_wide = WIDE_W'(issue_reg[COLOR_IDX_W-1:0]);
    // slots past the memory are dropped
    assign wr_en   = accept && (op == OP_WRITE) && ({1'b0, wr_wide} < DEPTH_C);
    assign limit_now = (count_reg > LIM_MAX_C) ? LIM_MAX_C : count_reg;

    npc_store #(
        .DEPTH (PALETTE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_wide[ADDR_W-1:0]),
        .wr_data (in_rgb),
        .rd_en   (rd_en),
        .rd_addr (rd_wide[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // cand_reg is aligned with rd_data (both are registered from the same scan step)
    npc_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .entry    (rd_data),
        .pixel    (pix_reg),
        .cand     (cand_reg),
        .done     (dist_done),
        .best_idx (dist_best)
    );

    // writes land only in idle and reads only while scanning, so memory
    // accesses never overlap on one entry
    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        issue_next     = issue_reg;
        pix_next       = pix_reg;
        res_idx_next   = res_idx_reg;
        res_empty_next = res_empty_reg;
        cand_next      = '0;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        start          = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (op == OP_LOOKUP))
                begin
                    limit_next = limit_now;
                    issue_next = '0;
                    pix_next   = in_rgb;
                    if (limit_now == '0)
                    begin
                        res_idx_next   = '0;
                        res_empty_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        start      = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < limit_reg)
                begin
                    rd_en           = 1'b1;
                    issue_next      = issue_reg + 1'b1;
                    cand_next.valid = 1'b1;
                    cand_next.last  = (issue_reg == (limit_reg - 1'b1));
                    cand_next.idx   = issue_reg[COLOR_IDX_W-1:0];
                end
                if (dist_done)
                begin
                    res_idx_next   = dist_best;
                    res_empty_next = 1'b0;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            limit_reg    <= '0;
            cand_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            limit_reg    <= limit_next;
            cand_reg     <= cand_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg       <= pix_next;
        res_idx_reg   <= res_idx_next;
        res_empty_reg <= res_empty_next;
        if (load_out)
        begin
            m_tdata_reg <= res_idx_reg;
            m_tuser_reg <= res_empty_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE))
        else $error("palette write outside idle");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= limit_reg))
        else $error("scan address past limit");

    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == ST_SCAN))
        else $error("search finished outside scan");

    a_empty_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("empty palette result with nonzero index");

endmodule
